>>> src/sspp_pkg.sv
// Servo status packet parser: shared types, codes and the sequencer's control store.
// No dependencies; used by servo_status_packet_parser.
package sspp_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hFF;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CSUM_BAD  = 2'd1;
    localparam logic [1:0] ST_SERVO_ERR = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    // register indexes
    localparam logic [0:0] REG_READ_BASE = 1'b0;

    typedef logic [3:0] step_t;
    typedef logic [3:0] act_t;
    typedef logic [2:0] cond_t;

    // program steps
    localparam step_t STEP_HDR1      = 4'd0;
    localparam step_t STEP_HDR2      = 4'd1;
    localparam step_t STEP_ID        = 4'd2;
    localparam step_t STEP_LEN       = 4'd3;
    localparam step_t STEP_ERR       = 4'd4;
    localparam step_t STEP_PARAM     = 4'd5;
    localparam step_t STEP_SUM       = 4'd6;
    localparam step_t STEP_CHK_ERR   = 4'd7;
    localparam step_t STEP_CHK_NP    = 4'd8;
    localparam step_t STEP_EMIT_MALF = 4'd9;
    localparam step_t STEP_EMIT_CSUM = 4'd10;
    localparam step_t STEP_EMIT_SERR = 4'd11;
    localparam step_t STEP_EMIT_OK   = 4'd12;
    localparam step_t STEP_RD        = 4'd13;
    localparam step_t STEP_EMIT_PAR  = 4'd14;

    // datapath actions
    localparam act_t ACT_NOP       = 4'd0;
    localparam act_t ACT_LD_ID     = 4'd1;
    localparam act_t ACT_LD_LEN    = 4'd2;
    localparam act_t ACT_LD_ERR    = 4'd3;
    localparam act_t ACT_LD_PARAM  = 4'd4;
    localparam act_t ACT_CLR_IDX   = 4'd5;
    localparam act_t ACT_RD_BUF    = 4'd6;
    localparam act_t ACT_EMIT_MALF = 4'd7;
    localparam act_t ACT_EMIT_CSUM = 4'd8;
    localparam act_t ACT_EMIT_SERR = 4'd9;
    localparam act_t ACT_EMIT_OK   = 4'd10;
    localparam act_t ACT_EMIT_PAR  = 4'd11;

    // branch conditions
    localparam cond_t C_ALWAYS     = 3'd0;
    localparam cond_t C_BYTE_FF    = 3'd1;
    localparam cond_t C_LEN_BAD    = 3'd2;
    localparam cond_t C_LEN_IS2    = 3'd3;
    localparam cond_t C_PARAM_DONE = 3'd4;
    localparam cond_t C_SUM_BAD    = 3'd5;
    localparam cond_t C_ERR_NZ     = 3'd6;
    localparam cond_t C_EMIT_LAST  = 3'd7;

    typedef struct packed {
        logic  wait_in;   // step consumes one rx word
        logic  emit;      // step loads the result register
        act_t  act;
        cond_t cond;
        step_t tgt_t;     // next step when cond holds
        step_t tgt_f;     // next step otherwise
    } cw_t;

    function automatic cw_t ucode(step_t pc);
        cw_t cw;
        unique case (pc)
            STEP_HDR1:      cw = '{1'b1, 1'b0, ACT_NOP,       C_BYTE_FF,
                                   STEP_HDR2, STEP_HDR1};
            STEP_HDR2:      cw = '{1'b1, 1'b0, ACT_NOP,       C_BYTE_FF,
                                   STEP_ID, STEP_HDR1};
            // 0xFF here is more preamble; id register is reloaded by the next word
            STEP_ID:        cw = '{1'b1, 1'b0, ACT_LD_ID,     C_BYTE_FF,
                                   STEP_ID, STEP_LEN};
            STEP_LEN:       cw = '{1'b1, 1'b0, ACT_LD_LEN,    C_LEN_BAD,
                                   STEP_EMIT_MALF, STEP_ERR};
            STEP_ERR:       cw = '{1'b1, 1'b0, ACT_LD_ERR,    C_LEN_IS2,
                                   STEP_SUM, STEP_PARAM};
            STEP_PARAM:     cw = '{1'b1, 1'b0, ACT_LD_PARAM,  C_PARAM_DONE,
                                   STEP_SUM, STEP_PARAM};
            STEP_SUM:       cw = '{1'b1, 1'b0, ACT_NOP,       C_SUM_BAD,
                                   STEP_EMIT_CSUM, STEP_CHK_ERR};
            STEP_CHK_ERR:   cw = '{1'b0, 1'b0, ACT_NOP,       C_ERR_NZ,
                                   STEP_EMIT_SERR, STEP_CHK_NP};
            STEP_CHK_NP:    cw = '{1'b0, 1'b0, ACT_CLR_IDX,   C_LEN_IS2,
                                   STEP_EMIT_OK, STEP_RD};
            STEP_EMIT_MALF: cw = '{1'b0, 1'b1, ACT_EMIT_MALF, C_ALWAYS,
                                   STEP_HDR1, STEP_HDR1};
            STEP_EMIT_CSUM: cw = '{1'b0, 1'b1, ACT_EMIT_CSUM, C_ALWAYS,
                                   STEP_HDR1, STEP_HDR1};
            STEP_EMIT_SERR: cw = '{1'b0, 1'b1, ACT_EMIT_SERR, C_ALWAYS,
                                   STEP_HDR1, STEP_HDR1};
            STEP_EMIT_OK:   cw = '{1'b0, 1'b1, ACT_EMIT_OK,   C_ALWAYS,
                                   STEP_HDR1, STEP_HDR1};
            STEP_RD:        cw = '{1'b0, 1'b0, ACT_RD_BUF,    C_ALWAYS,
                                   STEP_EMIT_PAR, STEP_EMIT_PAR};
            STEP_EMIT_PAR:  cw = '{1'b0, 1'b1, ACT_EMIT_PAR,  C_EMIT_LAST,
                                   STEP_HDR1, STEP_RD};
            default:        cw = '{1'b0, 1'b0, ACT_NOP,       C_ALWAYS,
                                   STEP_HDR1, STEP_HDR1};
        endcase
        return cw;
    endfunction

endpackage

>>> src/sspp_if.sv
// Servo status packet parser: valid/ready channel interfaces for rx words and results.
// No dependencies.
interface sspp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sspp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] servo_id;
    logic [1:0] status;
    logic [7:0] error_bits;
    logic       has_data;
    logic [7:0] table_address;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output servo_id, output status, output error_bits,
                    output has_data, output table_address, output data_byte,
                    output last, input ready);
    modport sink   (input valid, input servo_id, input status, input error_bits,
                    input has_data, input table_address, input data_byte,
                    input last, output ready);
endinterface

>>> src/sspp_ram.sv
// Servo status packet parser: generic single-write, single-read RAM, registered read.
// No dependencies.
module sspp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/servo_status_packet_parser.sv
// Servo status packet parser, top level: microcoded sequencer, datapath, APB register.
// Depends on sspp_pkg, sspp_if (sspp_rx_if, sspp_res_if) and sspp_ram.
//
//   channel   dir   handshake        payload
//   rx        in    valid/ready      rx_byte[7:0]
//   res       out   valid/ready      servo_id, status, error_bits, has_data,
//                                    table_address, data_byte, last
//   apb       in    psel/penable     paddr[2:0], pwdata/prdata[31:0], pready = 1
//
// Each rx word is taken on one step of the step counter; rx.ready is high only on steps that
// take a word. After the checksum word a bad checksum goes straight to its emit step, a
// servo error passes the error check first, and a good packet with no parameters passes
// the error and parameter-count checks; N parameters take those two decision steps, then a
// RAM read and an emit step each. A malformed length goes from the length step to its
// emit step. A held result register freezes the step counter on an emit step. rst_n is
// asynchronous; after reset the sequencer hunts for the header.
module servo_status_packet_parser #(
    parameter int MAX_PARAMS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sspp_rx_if.sink     rx,
    sspp_res_if.source  res
);

    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam logic [7:0] LEN_MAX = 8'(MAX_PARAMS + 2);
    localparam logic [6:0] CNT_LIM = 7'(MAX_PARAMS);

    sspp_pkg::step_t pc_reg, pc_next;
    sspp_pkg::cw_t   cw;

    logic [7:0]       base_reg;
    logic [7:0]       id_reg;
    logic [7:0]       len_reg;
    logic [7:0]       err_reg;
    logic [7:0]       sum_reg;
    logic [6:0]       cnt_reg;
    logic [IDX_W-1:0] idx_reg;

    logic             out_valid_reg;
    logic [7:0]       out_id_reg;
    logic [1:0]       out_status_reg;
    logic [7:0]       out_err_reg;
    logic             out_hd_reg;
    logic [7:0]       out_addr_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;

    logic [7:0] b;
    logic [6:0] cnt_inc;
    logic       out_free;
    logic       fire;
    logic       cond_true;
    logic       ram_we;
    logic       ram_re;
    logic [7:0] ram_rdata;
    logic       cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == sspp_pkg::REG_READ_BASE)
        begin
            prdata = {24'd0, base_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_wr && paddr[2] == sspp_pkg::REG_READ_BASE)
        begin
            base_reg <= pwdata[7:0];
        end
    end

    // ---------------- sequencer ----------------
    assign cw       = sspp_pkg::ucode(pc_reg);
    assign b        = rx.rx_byte;
    assign cnt_inc  = cnt_reg + 7'd1;
    assign out_free = !out_valid_reg || res.ready;
    assign rx.ready = cw.wait_in;
    assign fire     = (!cw.wait_in || rx.valid) && (!cw.emit || out_free);

    always_comb
    begin
        unique case (cw.cond)
            sspp_pkg::C_ALWAYS:     cond_true = 1'b1;
            sspp_pkg::C_BYTE_FF:    cond_true = (b == sspp_pkg::HDR_BYTE);
            sspp_pkg::C_LEN_BAD:    cond_true = (b < 8'd2) || (b > LEN_MAX);
            sspp_pkg::C_LEN_IS2:    cond_true = (len_reg == 8'd2);
            sspp_pkg::C_PARAM_DONE: cond_true = ({2'b00, cnt_inc} + 9'd2) >= {1'b0, len_reg};
            sspp_pkg::C_SUM_BAD:    cond_true = (b != ~sum_reg);
            sspp_pkg::C_ERR_NZ:     cond_true = (err_reg != 8'd0);
            sspp_pkg::C_EMIT_LAST:  cond_true = (8'(idx_reg) + 8'd3) == len_reg;
            default:                cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (fire)
        begin
            pc_next = cond_true ? cw.tgt_t : cw.tgt_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= sspp_pkg::STEP_HDR1;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= '0;
            len_reg <= '0;
            err_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (fire)
        begin
            case (cw.act)
                sspp_pkg::ACT_LD_ID:
                begin
                    id_reg  <= b;
                    sum_reg <= b;
                end
                sspp_pkg::ACT_LD_LEN:
                begin
                    len_reg <= b;
                    sum_reg <= sum_reg + b;
                    cnt_reg <= '0;
                end
                sspp_pkg::ACT_LD_ERR:
                begin
                    err_reg <= b;
                    sum_reg <= sum_reg + b;
                end
                sspp_pkg::ACT_LD_PARAM:
                begin
                    cnt_reg <= cnt_inc;
                    sum_reg <= sum_reg + b;
                end
                sspp_pkg::ACT_CLR_IDX:  idx_reg <= '0;
                sspp_pkg::ACT_EMIT_PAR: idx_reg <= idx_reg + 1'b1;
                default: ;
            endcase
        end
    end

    assign ram_we = fire && (cw.act == sspp_pkg::ACT_LD_PARAM) && (cnt_reg < CNT_LIM);
    assign ram_re = fire && (cw.act == sspp_pkg::ACT_RD_BUF);

    sspp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PARAMS),
        .AW    (IDX_W)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (b),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && cw.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && cw.emit)
        begin
            out_id_reg     <= id_reg;
            out_status_reg <= sspp_pkg::ST_OK;
            out_err_reg    <= '0;
            out_hd_reg     <= 1'b0;
            out_addr_reg   <= '0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b1;
            case (cw.act)
                sspp_pkg::ACT_EMIT_MALF: out_status_reg <= sspp_pkg::ST_MALFORMED;
                sspp_pkg::ACT_EMIT_CSUM:
                begin
                    out_status_reg <= sspp_pkg::ST_CSUM_BAD;
                    out_err_reg    <= err_reg;
                end
                sspp_pkg::ACT_EMIT_SERR:
                begin
                    out_status_reg <= sspp_pkg::ST_SERVO_ERR;
                    out_err_reg    <= err_reg;
                end
                sspp_pkg::ACT_EMIT_PAR:
                begin
                    out_hd_reg   <= 1'b1;
                    out_addr_reg <= base_reg + 8'(idx_reg);
                    out_data_reg <= ram_rdata;
                    out_last_reg <= cond_true;
                end
                default: ;
            endcase
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.servo_id      = out_id_reg;
    assign res.status        = out_status_reg;
    assign res.error_bits    = out_err_reg;
    assign res.has_data      = out_hd_reg;
    assign res.table_address = out_addr_reg;
    assign res.data_byte     = out_data_reg;
    assign res.last          = out_last_reg;

    // ---------------- assertions ----------------
    a_param_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.has_data |-> res.status == sspp_pkg::ST_OK)
        else $error("parameter word with nonzero status");

    a_nonlast_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.last |-> res.has_data)
        else $error("status word not marked last");

    a_count_at_sum: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == sspp_pkg::STEP_SUM |-> (8'(cnt_reg) + 8'd2) == len_reg)
        else $error("parameter count disagrees with length at checksum");

    a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cw.emit && !out_free |=> pc_reg == $past(pc_reg))
        else $error("sequencer advanced past a blocked emit step");

endmodule
